// ----- design/mce_pkg.sv -----
// Shared types, constants and the character code table of the Morse encoder.
package mce_pkg;

  // Symbol codes carried on the result channel.
  typedef logic [1:0] mark_t;
  localparam mark_t MK_DOT     = 2'd0;
  localparam mark_t MK_DASH    = 2'd1;
  localparam mark_t MK_BAR     = 2'd2;
  localparam mark_t MK_UNKNOWN = 2'd3;

  // Run geometry: the longest run is one bar plus six code symbols.
  localparam int unsigned CODE_MAX  = 6;
  localparam int unsigned RUN_MAX   = 7;
  localparam int unsigned WORD_BARS = 7;
  localparam int unsigned RUN_BITS  = 2 * RUN_MAX;
  localparam int unsigned CNT_BITS  = $clog2(RUN_MAX + 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One table entry: code length, dash bits first symbol at the MSB, hit flag.
  typedef struct packed {
    logic                found;
    logic [CNT_BITS-1:0] len;
    logic [CODE_MAX-1:0] dashes;
  } code_t;

  // Control from the sequencer to the symbol shifter.
  typedef struct packed {
    logic                load;
    logic                shift;
    logic [RUN_BITS-1:0] run;
    logic [CNT_BITS-1:0] cnt;
  } shift_ctl_t;

  // Status from the symbol shifter back to the sequencer.
  typedef struct packed {
    logic  last;
    mark_t head;
  } shift_sts_t;

  // Folds lower case to upper case and looks the character up in the code table.
  function automatic code_t mce_lookup(input logic [7:0] c_in);
    logic [7:0] c;
    code_t      e;
    c = c_in;
    if (c inside {[8'h61:8'h7A]}) begin
      c = c - CASE_DELTA;
    end
    e = '{found: 1'b1, len: '0, dashes: '0};
    case (c)
      "A":     e = '{1'b1, 3'd2, 6'b010000};
      "B":     e = '{1'b1, 3'd4, 6'b100000};
      "C":     e = '{1'b1, 3'd4, 6'b101000};
      "D":     e = '{1'b1, 3'd3, 6'b100000};
      "E":     e = '{1'b1, 3'd1, 6'b000000};
      "F":     e = '{1'b1, 3'd4, 6'b001000};
      "G":     e = '{1'b1, 3'd3, 6'b110000};
      "H":     e = '{1'b1, 3'd4, 6'b000000};
      "I":     e = '{1'b1, 3'd2, 6'b000000};
      "J":     e = '{1'b1, 3'd4, 6'b011100};
      "K":     e = '{1'b1, 3'd3, 6'b101000};
      "L":     e = '{1'b1, 3'd4, 6'b010000};
      "M":     e = '{1'b1, 3'd2, 6'b110000};
      "N":     e = '{1'b1, 3'd2, 6'b100000};
      "O":     e = '{1'b1, 3'd3, 6'b111000};
      "P":     e = '{1'b1, 3'd4, 6'b011000};
      "Q":     e = '{1'b1, 3'd4, 6'b110100};
      "R":     e = '{1'b1, 3'd3, 6'b010000};
      "S":     e = '{1'b1, 3'd3, 6'b000000};
      "T":     e = '{1'b1, 3'd1, 6'b100000};
      "U":     e = '{1'b1, 3'd3, 6'b001000};
      "V":     e = '{1'b1, 3'd4, 6'b000100};
      "W":     e = '{1'b1, 3'd3, 6'b011000};
      "X":     e = '{1'b1, 3'd4, 6'b100100};
      "Y":     e = '{1'b1, 3'd4, 6'b101100};
      "Z":     e = '{1'b1, 3'd4, 6'b110000};
      "0":     e = '{1'b1, 3'd5, 6'b111110};
      "1":     e = '{1'b1, 3'd5, 6'b011110};
      "2":     e = '{1'b1, 3'd5, 6'b001110};
      "3":     e = '{1'b1, 3'd5, 6'b000110};
      "4":     e = '{1'b1, 3'd5, 6'b000010};
      "5":     e = '{1'b1, 3'd5, 6'b000000};
      "6":     e = '{1'b1, 3'd5, 6'b100000};
      "7":     e = '{1'b1, 3'd5, 6'b110000};
      "8":     e = '{1'b1, 3'd5, 6'b111000};
      "9":     e = '{1'b1, 3'd5, 6'b111100};
      ".":     e = '{1'b1, 3'd6, 6'b010101};
      ",":     e = '{1'b1, 3'd6, 6'b110011};
      ":":     e = '{1'b1, 3'd6, 6'b111000};
      "?":     e = '{1'b1, 3'd6, 6'b001100};
      "=":     e = '{1'b1, 3'd5, 6'b100010};
      "-":     e = '{1'b1, 3'd6, 6'b100001};
      "(":     e = '{1'b1, 3'd5, 6'b101100};
      ")":     e = '{1'b1, 3'd6, 6'b101101};
      8'h22:   e = '{1'b1, 3'd6, 6'b010010};
      8'h27:   e = '{1'b1, 3'd6, 6'b011110};
      "/":     e = '{1'b1, 3'd5, 6'b100100};
      "_":     e = '{1'b1, 3'd6, 6'b001101};
      "@":     e = '{1'b1, 3'd6, 6'b011010};
      "!":     e = '{1'b1, 3'd6, 6'b101011};
      default: e = '{1'b0, 3'd0, 6'b000000};
    endcase
    return e;
  endfunction

endpackage

// ----- design/mce_if.sv -----
// Valid/ready channel interfaces for the character input and the symbol output.
interface mce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface mce_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mark;
  logic       last_of_run;

  modport source (output valid, output mark, output last_of_run, input ready);
  modport sink (input valid, input mark, input last_of_run, output ready);
endinterface

// ----- design/morse_character_encoder.sv -----
// Morse encoder top level: sequencer, gap flag and run assembly around the symbol shifter.
//
// The block takes one text byte on the in_ch channel and answers with a run of
// Morse symbols on out_ch: dot, dash, separator bar or the unknown marker, with
// last_of_run set on the final symbol of the run. A space gives seven bars; any
// other byte gives an optional leading bar, owed after a previous non-space
// character, and then its code, or a single unknown marker if it has none.
// Lower-case letters are treated as upper case.
// Both channels use valid/ready; a request moves when both are high.
// The byte is looked up in the cycle it is accepted, and the first symbol is
// on out_ch in the next cycle. One symbol leaves per cycle while out_ch is
// ready; a byte gives a run of n symbols (1 to 7), and the single symbol
// shift register is the limit on rate.
// in_ch.ready is low while a run is being sent.
// When the receiver stalls, the current symbol is held unchanged on out_ch.
// Synchronous reset returns the sequencer to idle, empties the run and clears
// the owed-bar flag; no clearing pass is needed.
module morse_character_encoder
  import mce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  mce_in_if.sink           in_ch,
  mce_out_if.source        out_ch
);

  state_t     state_r, state_nxt;
  logic       pend_r, pend_nxt;
  shift_ctl_t ctl;
  shift_sts_t sts;
  code_t      code;
  logic       in_acc;
  logic       out_acc;
  logic       is_space;
  logic [RUN_BITS-3:0] code_marks;
  logic [CNT_BITS-1:0] code_len;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign is_space = (in_ch.char_byte == CHAR_SPACE);
  assign code     = mce_lookup(in_ch.char_byte);

  // Expand the table entry into a left-justified string of marks.
  always_comb begin
    code_marks = '0;
    code_len   = code.len;
    if (!code.found) begin
      code_marks[RUN_BITS-3 -: 2] = MK_UNKNOWN;
      code_len                    = CNT_BITS'(1);
    end else begin
      for (int j = 0; j < CODE_MAX; j++) begin
        if (CNT_BITS'(j) < code.len) begin
          code_marks[RUN_BITS-3-2*j -: 2] = code.dashes[CODE_MAX-1-j] ? MK_DASH : MK_DOT;
        end
      end
    end
  end

  // Assemble the run handed to the shifter, with the owed bar in front.
  always_comb begin
    ctl.load  = in_acc;
    ctl.shift = out_acc;
    if (is_space) begin
      ctl.run = {RUN_MAX{MK_BAR}};
      ctl.cnt = CNT_BITS'(WORD_BARS);
    end else if (pend_r) begin
      ctl.run = {MK_BAR, code_marks};
      ctl.cnt = code_len + CNT_BITS'(1);
    end else begin
      ctl.run = {code_marks, 2'b00};
      ctl.cnt = code_len;
    end
  end

  mce_sym_shift u_shift (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  // Sequencer: idle takes a byte, run sends its symbols.
  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          pend_nxt  = !is_space;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign out_ch.mark        = sts.head;
  assign out_ch.last_of_run = sts.last;

  // Input and output never move in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted while a run is being sent");

  // A space starts with a bar and clears the owed-bar flag.
  a_space_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_space) |=> (out_ch.mark == MK_BAR) && !pend_r)
    else $error("space did not start a bar run");

  // An owed bar always leads the run of a non-space byte.
  a_gap_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_space && pend_r) |=> (out_ch.mark == MK_BAR) && !out_ch.last_of_run)
    else $error("owed bar missing");

  // After the last symbol leaves, the block is ready again.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last_of_run) |=> in_ch.ready && !out_ch.valid)
    else $error("block not idle after the last symbol");

endmodule

// ----- design/mce_sym_shift.sv -----
// Symbol shifter: holds the run of one character and steps out one mark per request.
module mce_sym_shift
  import mce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  shift_ctl_t ctl,
  output shift_sts_t sts
);

  logic [RUN_BITS-1:0] run_r, run_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  // Load a new run or move the next mark to the head.
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      run_nxt = ctl.run;
      cnt_nxt = ctl.cnt;
    end else if (ctl.shift) begin
      run_nxt = {run_r[RUN_BITS-3:0], 2'b00};
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  // The count is control state; the run itself is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  assign sts.head = run_r[RUN_BITS-1 -: 2];
  assign sts.last = (cnt_r == CNT_BITS'(1));

endmodule

// ----- verif/mce_checker.sv -----
`timescale 1ns / 100ps
// Symbol stream checker: predicts the Morse run of each accepted character and compares the output.
module mce_checker
  import mce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mce_in_if           in_mon,
  mce_out_if          out_mon,
  output int unsigned error_count,
  output int unsigned symbols_owed
);

  typedef struct packed {
    mark_t mark;
    logic  last;
  } symbol_t;

  localparam int unsigned PRINT_LIMIT = 40;

  symbol_t     expected_symbols[$];
  symbol_t     want;
  logic        gap_owed = 1'b0;
  int unsigned errors = 0;
  int unsigned symbols_seen = 0;
  int unsigned errors_q = 0;
  int unsigned owed_q = 0;

  assign error_count  = errors_q;
  assign symbols_owed = owed_q;

  // Dot/dash pattern of an upper-case character; empty when it has no code.
  function automatic string dit_dah(input logic [7:0] c);
    case (c)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-";
      ",": return "--..--";
      ":": return "---...";
      "?": return "..--..";
      "=": return "-...-";
      "-": return "-....-";
      "(": return "-.--.";
      ")": return "-.--.-";
      8'h22: return ".-..-.";  // double quote
      8'h27: return ".----.";  // apostrophe
      "/": return "-..-.";
      "_": return "..--.-";
      "@": return ".--.-.";
      "!": return "-.-.--";
      default: return "";
    endcase
  endfunction

  // Works out the symbol run of one character and queues it.
  task automatic predict_run(input logic [7:0] raw);
    mark_t      run [RUN_MAX];
    int         n;
    logic [7:0] c;
    string      code;
    n = 0;
    c = raw;
    if (raw == CHAR_SPACE) begin
      // A word space is always seven bars and cancels any owed bar.
      for (int j = 0; j < WORD_BARS; j++) begin
        run[n] = MK_BAR;
        n++;
      end
      gap_owed = 1'b0;
    end else begin
      if (c >= "a" && c <= "z") begin
        c = c - CASE_DELTA;
      end
      if (gap_owed) begin
        run[n] = MK_BAR;
        n++;
      end
      code = dit_dah(c);
      if (code.len() == 0) begin
        run[n] = MK_UNKNOWN;
        n++;
      end else begin
        for (int j = 0; j < code.len(); j++) begin
          run[n] = (code[j] == "-") ? MK_DASH : MK_DOT;
          n++;
        end
      end
      gap_owed = 1'b1;
    end
    for (int j = 0; j < n; j++) begin
      expected_symbols.push_back('{mark: run[j], last: (j == n - 1)});
    end
  endtask

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_symbol_error(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("%0t ns: symbol %0d: %s", $time, symbols_seen, what);
    end
  endtask

  // Requests in are predicted, symbols out are compared against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        predict_run(in_mon.char_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_symbols.size() == 0) begin
          report_symbol_error($sformatf("unexpected symbol mark=%0d last=%0b",
                                        out_mon.mark, out_mon.last_of_run));
        end else begin
          want = expected_symbols.pop_front();
          if (out_mon.mark !== want.mark) begin
            report_symbol_error($sformatf("mark %0d, expected %0d", out_mon.mark, want.mark));
          end
          if (out_mon.last_of_run !== want.last) begin
            report_symbol_error($sformatf("last_of_run %0b, expected %0b",
                                          out_mon.last_of_run, want.last));
          end
        end
        symbols_seen++;
      end
    end
    errors_q <= errors;
    owed_q   <= expected_symbols.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Encoder testbench top: clock, reset, character stimulus, receiver stalls and the verdict.
module testbench
  import mce_pkg::*;
();

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 102;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned error_count;
  int unsigned symbols_owed;

  mce_in_if  in_ch ();
  mce_out_if out_ch ();

  morse_character_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mce_checker symbol_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .error_count  (error_count),
    .symbols_owed (symbols_owed)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off each time hold_req toggles.
  initial begin
    logic        hold_seen;
    int unsigned hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one character, possibly after an idle gap, and returns at the edge it is taken.
  task automatic send_char(input logic [7:0] c);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering until every predicted symbol has come out.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (symbols_owed != 0) @(posedge clk);
  endtask

  // Mostly text words with random content, some raw bytes as noise.
  function automatic logic [7:0] pick_char();
    string       punct;
    int unsigned roll;
    punct = ".,:?=-()\"'/_@!";
    roll  = $urandom_range(99);
    if (roll < 14) return CHAR_SPACE;
    else if (roll < 48) return 8'("A" + $urandom_range(25));
    else if (roll < 64) return 8'("a" + $urandom_range(25));
    else if (roll < 76) return 8'("0" + $urandom_range(9));
    else if (roll < 88) return punct[$urandom_range(punct.len() - 1)];
    else return 8'($urandom_range(255));
  endfunction

  // Stimulus: reset, directed characters, then four random phases of idling and receiver stalls.
  initial begin
    logic [7:0]  directed [24];
    int unsigned settle;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = 8'h00;
    // Space out of reset, plain and folded A, quote, longest run, byte extremes,
    // spaces after a character and after a space, case-fold borders, punctuation.
    directed = '{CHAR_SPACE, "A", "a", 8'h22, ".", 8'h00, 8'hFF, 8'h80, 8'h7F,
                 CHAR_SPACE, CHAR_SPACE, "z", "0", "9", "!", "@", "_", 8'h60,
                 8'h7B, "[", 8'h27, "/", CHAR_SPACE, "E"};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_char(directed[i]);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 76;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 76;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct <= 16;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Long receiver hold-off while characters keep coming.
        if (phase == 0 && k == 20) begin
          hold_req <= ~hold_req;
        end
        if (phase == 1 && k == 50) begin
          wait_for_drain();
        end
        send_char(pick_char());
      end
    end
    in_ch.valid <= 1'b0;

    // Let the last runs drain, then watch a little longer for stray symbols.
    settle = 0;
    @(posedge clk);
    while (symbols_owed != 0 && settle < DRAIN_LIMIT) begin
      @(posedge clk);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && symbols_owed == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- morse_character_encoder.f -----
design/mce_pkg.sv
design/mce_if.sv
design/mce_sym_shift.sv
design/morse_character_encoder.sv
verif/mce_checker.sv
verif/testbench.sv
